### rtl/tccb_pkg.sv
// Shared types and constants of the text console cell buffer.
package tccb_pkg;

  // Field widths of the request and result channels.
  localparam int unsigned CmdW      = 3;
  localparam int unsigned CharW     = 8;
  localparam int unsigned ReqRowW   = 5;
  localparam int unsigned ReqColW   = 7;
  localparam int unsigned CfgRowsW  = 6;
  localparam int unsigned CfgColsW  = 8;
  localparam int unsigned CfgIndexW = 1;
  localparam int unsigned CfgDataW  = 8;

  // Reset values of the configuration registers.
  localparam logic [CfgRowsW-1:0] RowsUsedReset    = 6'd25;
  localparam logic [CfgColsW-1:0] ColumnsUsedReset = 8'd80;

  // Configuration register indexes.
  localparam logic [CfgIndexW-1:0] CfgIdxRowsUsed    = 1'b0;
  localparam logic [CfgIndexW-1:0] CfgIdxColumnsUsed = 1'b1;

  // Command codes carried by a request.
  typedef enum logic [CmdW-1:0] {
    CMD_PUT_CHAR  = 3'd0,
    CMD_BACKSPACE = 3'd1,
    CMD_NEWLINE   = 3'd2,
    CMD_CLEAR     = 3'd3,
    CMD_READ_CELL = 3'd4
  } cmd_e;

  // Configuration register contents handed to the controller.
  typedef struct packed {
    logic [CfgRowsW-1:0] rows_used;
    logic [CfgColsW-1:0] columns_used;
  } cfg_t;

endpackage

### rtl/tccb_modsub.sv
// Shared compare-and-subtract unit used for all row arithmetic modulo the rows in use.
module tccb_modsub import tccb_pkg::*; #(
  parameter int unsigned W = 6
) (
  input  logic [W-1:0] x_i,
  input  logic [W-1:0] m_i,
  output logic [W-1:0] y_o,
  output logic         ge_o
);

  // One reduction step: subtract the modulus when the value reaches it.
  always_comb begin
    ge_o = (x_i >= m_i);
    y_o  = ge_o ? (x_i - m_i) : x_i;
  end

endmodule

### rtl/tccb_cell_mem.sv
// Single-port character cell store with registered read data.
module tccb_cell_mem import tccb_pkg::*; #(
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned AW    = 12
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic             re_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [CharW-1:0] wdata_i,
  output logic [CharW-1:0] rdata_o
);

  logic [CharW-1:0] mem_q [DEPTH];
  logic [CharW-1:0] rdata_q;

  // One access per cycle: a write or a read at the shared address.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/tccb_ctrl.sv
// Command sequencer: cursor, top row offset, sweeps and the result register.
module tccb_ctrl import tccb_pkg::*; #(
  parameter int unsigned MAX_ROWS = 32,
  parameter int unsigned MAX_COLS = 128,
  parameter int unsigned DEPTH    = MAX_ROWS * MAX_COLS,
  parameter int unsigned AW       = $clog2(DEPTH)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cfg_t                cfg_i,
  // Request channel
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [CmdW-1:0]     cmd_i,
  input  logic [CharW-1:0]    char_code_i,
  input  logic [ReqRowW-1:0]  read_row_i,
  input  logic [ReqColW-1:0]  read_col_i,
  // Result channel
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [ReqRowW-1:0]  cursor_row_o,
  output logic [ReqColW-1:0]  cursor_col_o,
  output logic [CharW-1:0]    read_char_o,
  output logic                scrolled_o,
  // Cell store port
  output logic                mem_we_o,
  output logic                mem_re_o,
  output logic [AW-1:0]       mem_addr_o,
  output logic [CharW-1:0]    mem_wdata_o,
  input  logic [CharW-1:0]    mem_rdata_i
);

  localparam int unsigned ROW_W = $clog2(MAX_ROWS);
  localparam int unsigned COL_W = $clog2(MAX_COLS);
  localparam int unsigned RN_W  = $clog2(MAX_ROWS + 1);
  localparam int unsigned CN_W  = $clog2(MAX_COLS + 1);
  localparam int unsigned SW    = $clog2(2 * MAX_ROWS);

  typedef enum logic [3:0] {
    S_IDLE,
    S_NORM,
    S_ADDR,
    S_EXEC,
    S_SCROLL,
    S_PUTCH,
    S_CLEAR,
    S_RDWAIT,
    S_DONE
  } state_e;

  state_e              state_q;
  logic [CmdW-1:0]     cmd_q;
  logic [CharW-1:0]    ch_q;
  logic [ReqRowW-1:0]  rr_q;
  logic [ReqColW-1:0]  rc_q;
  logic [ROW_W-1:0]    cur_row_q;
  logic [COL_W-1:0]    cur_col_q;
  logic [ROW_W-1:0]    off_q;
  logic [ROW_W-1:0]    phys_q;
  logic [COL_W-1:0]    tcol_q;
  logic [ROW_W-1:0]    scroll_row_q;
  logic [AW-1:0]       sweep_q;
  logic                put_pend_q;
  logic                report_q;
  logic                scr_q;
  logic [CharW-1:0]    rd_q;
  logic                out_valid_q;
  logic [ReqRowW-1:0]  out_row_q;
  logic [ReqColW-1:0]  out_col_q;
  logic [CharW-1:0]    out_char_q;
  logic                out_scr_q;

  logic [RN_W-1:0]     eff_rows;
  logic [CN_W-1:0]     eff_cols;
  logic [ROW_W-1:0]    sat_row;
  logic [COL_W-1:0]    sat_col;
  logic                col_last;
  logic                row_last;
  logic                read_ok;
  logic [SW-1:0]       ms_x;
  logic [SW-1:0]       ms_m;
  logic [SW-1:0]       ms_y;
  logic                ms_ge;
  logic [SW-1:0]       vrow;

  // Store address of a physical row and column.
  function automatic logic [AW-1:0] cell_addr(input logic [ROW_W-1:0] r,
                                              input logic [COL_W-1:0] c);
    return AW'(32'(r) * MAX_COLS + 32'(c));
  endfunction

  // Rows and columns in use, saturated to the supported range.
  always_comb begin
    if (cfg_i.rows_used == '0) begin
      eff_rows = RN_W'(1);
    end else if (32'(cfg_i.rows_used) > MAX_ROWS) begin
      eff_rows = RN_W'(MAX_ROWS);
    end else begin
      eff_rows = RN_W'(cfg_i.rows_used);
    end
    if (cfg_i.columns_used == '0) begin
      eff_cols = CN_W'(1);
    end else if (32'(cfg_i.columns_used) > MAX_COLS) begin
      eff_cols = CN_W'(MAX_COLS);
    end else begin
      eff_cols = CN_W'(cfg_i.columns_used);
    end
  end

  // Cursor pulled back inside a screen that may have shrunk.
  always_comb begin
    sat_row = (RN_W'(cur_row_q) >= eff_rows) ? ROW_W'(eff_rows - RN_W'(1)) : cur_row_q;
    sat_col = (CN_W'(cur_col_q) >= eff_cols) ? COL_W'(eff_cols - CN_W'(1)) : cur_col_q;
  end

  // Position tests used while a command executes.
  always_comb begin
    col_last = !((CN_W'(cur_col_q) + CN_W'(1)) < eff_cols);
    row_last = !((RN_W'(cur_row_q) + RN_W'(1)) < eff_rows);
    read_ok  = (32'(rr_q) < 32'(eff_rows)) && (32'(rc_q) < 32'(eff_cols));
  end

  // Operand selection for the shared modulo unit.
  always_comb begin
    vrow = (cmd_q == CMD_READ_CELL) ? SW'(rr_q) : SW'(cur_row_q);
    ms_m = SW'(eff_rows);
    case (state_q)
      S_NORM:  ms_x = SW'(off_q);
      S_ADDR:  ms_x = SW'(off_q) + vrow;
      default: ms_x = SW'(off_q) + SW'(1);
    endcase
  end

  tccb_modsub #(
    .W (SW)
  ) u_modsub (
    .x_i  (ms_x),
    .m_i  (ms_m),
    .y_o  (ms_y),
    .ge_o (ms_ge)
  );

  // Cell store access for the current step.
  always_comb begin
    mem_we_o    = 1'b0;
    mem_re_o    = 1'b0;
    mem_addr_o  = cell_addr(phys_q, tcol_q);
    mem_wdata_o = '0;
    case (state_q)
      S_EXEC: begin
        case (cmd_q)
          CMD_PUT_CHAR: begin
            mem_we_o    = !col_last || !row_last;
            mem_wdata_o = ch_q;
          end
          CMD_BACKSPACE, CMD_NEWLINE: begin
            mem_we_o = 1'b1;
          end
          CMD_READ_CELL: begin
            mem_re_o = read_ok;
          end
          default: begin
            mem_we_o = 1'b0;
          end
        endcase
      end
      S_SCROLL: begin
        mem_we_o   = 1'b1;
        mem_addr_o = cell_addr(scroll_row_q, COL_W'(sweep_q));
      end
      S_PUTCH: begin
        mem_we_o    = 1'b1;
        mem_wdata_o = ch_q;
      end
      S_CLEAR: begin
        mem_we_o   = 1'b1;
        mem_addr_o = sweep_q;
      end
      default: begin
        mem_we_o = 1'b0;
      end
    endcase
  end

  // Sequencer, console state and result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      cmd_q        <= '0;
      ch_q         <= '0;
      rr_q         <= '0;
      rc_q         <= '0;
      cur_row_q    <= '0;
      cur_col_q    <= '0;
      off_q        <= '0;
      phys_q       <= '0;
      tcol_q       <= '0;
      scroll_row_q <= '0;
      sweep_q      <= '0;
      put_pend_q   <= 1'b0;
      report_q     <= 1'b0;
      scr_q        <= 1'b0;
      rd_q         <= '0;
      out_valid_q  <= 1'b0;
      out_row_q    <= '0;
      out_col_q    <= '0;
      out_char_q   <= '0;
      out_scr_q    <= 1'b0;
    end else begin
      // A taken result frees the register unless a new one replaces it now.
      if (out_valid_q && !out_stall_i && (state_q != S_DONE)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            cmd_q     <= cmd_i;
            ch_q      <= char_code_i;
            rr_q      <= read_row_i;
            rc_q      <= read_col_i;
            cur_row_q <= sat_row;
            cur_col_q <= sat_col;
            scr_q     <= 1'b0;
            rd_q      <= '0;
            report_q  <= 1'b1;
            state_q   <= S_NORM;
          end
        end
        S_NORM: begin
          // Reduce the top offset one subtraction per cycle.
          if (ms_ge) begin
            off_q <= ROW_W'(ms_y);
          end else begin
            state_q <= S_ADDR;
          end
        end
        S_ADDR: begin
          phys_q  <= ROW_W'(ms_y);
          tcol_q  <= (cmd_q == CMD_READ_CELL) ? COL_W'(rc_q) : cur_col_q;
          state_q <= S_EXEC;
        end
        S_EXEC: begin
          case (cmd_q)
            CMD_PUT_CHAR, CMD_NEWLINE: begin
              if ((cmd_q == CMD_PUT_CHAR) && !col_last) begin
                cur_col_q <= cur_col_q + COL_W'(1);
                state_q   <= S_DONE;
              end else begin
                cur_col_q <= '0;
                if (!row_last) begin
                  cur_row_q <= cur_row_q + ROW_W'(1);
                  state_q   <= S_DONE;
                end else begin
                  // Scroll: the old top row becomes the new, blank bottom row.
                  scroll_row_q <= off_q;
                  off_q        <= ROW_W'(ms_y);
                  scr_q        <= 1'b1;
                  sweep_q      <= '0;
                  put_pend_q   <= (cmd_q == CMD_PUT_CHAR);
                  state_q      <= S_SCROLL;
                end
              end
            end
            CMD_BACKSPACE: begin
              if (cur_col_q != '0) begin
                cur_col_q <= cur_col_q - COL_W'(1);
              end
              state_q <= S_DONE;
            end
            CMD_CLEAR: begin
              cur_row_q <= '0;
              cur_col_q <= '0;
              off_q     <= '0;
              sweep_q   <= '0;
              state_q   <= S_CLEAR;
            end
            CMD_READ_CELL: begin
              state_q <= read_ok ? S_RDWAIT : S_DONE;
            end
            default: begin
              state_q <= S_DONE;
            end
          endcase
        end
        S_SCROLL: begin
          if (sweep_q == AW'(MAX_COLS - 1)) begin
            state_q <= put_pend_q ? S_PUTCH : S_DONE;
          end else begin
            sweep_q <= sweep_q + AW'(1);
          end
        end
        S_PUTCH: begin
          state_q <= S_DONE;
        end
        S_CLEAR: begin
          if (sweep_q == AW'(DEPTH - 1)) begin
            state_q <= report_q ? S_DONE : S_IDLE;
          end else begin
            sweep_q <= sweep_q + AW'(1);
          end
        end
        S_RDWAIT: begin
          rd_q    <= mem_rdata_i;
          state_q <= S_DONE;
        end
        S_DONE: begin
          // Load the result register once the previous result has left.
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q <= 1'b1;
            out_row_q   <= ReqRowW'(cur_row_q);
            out_col_q   <= ReqColW'(cur_col_q);
            out_char_q  <= rd_q;
            out_scr_q   <= scr_q;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign in_stall_o   = (state_q != S_IDLE);
  assign out_valid_o  = out_valid_q;
  assign cursor_row_o = out_row_q;
  assign cursor_col_o = out_col_q;
  assign read_char_o  = out_char_q;
  assign scrolled_o   = out_scr_q;

endmodule

### rtl/text_console_cell_buffer.sv
// Top level of the text console cell buffer: configuration registers, sequencer and cell store.
//
// Usage:
//   Requests enter on the in_* channel (valid/stall) and carry a command, a character and a
//   read position. Each request produces exactly one result on the out_* channel (valid/stall):
//   the cursor after the command, the cell read by a read request, and a scroll flag.
//   Configuration (rows_used at index 0, columns_used at index 1) is written on the cfg_*
//   channel, which is always ready; write it only while no request is in flight.
//   One request is worked on at a time; in_stall_o is high from acceptance until the result
//   is placed in the output register. From acceptance a request passes through S_NORM (top
//   offset reduction), S_ADDR (address forming) and S_EXEC, a read that hits the screen also
//   through S_RDWAIT, and then S_DONE loads the result; the next request is taken in S_IDLE.
//   Reducing a stale top offset after rows_used shrinks repeats S_NORM once per subtraction.
//   A scroll sweeps one row of the store, all MAX_COLS cells (then S_PUTCH writes a wrapping
//   char); clear screen sweeps the whole store, MAX_ROWS*MAX_COLS cells (4096 by default).
//   After reset the block first zeroes the store in the same sweep of MAX_ROWS*MAX_COLS
//   cells, with in_stall_o high; configuration writes are taken during that time.
//   When the receiver stalls, the result waits in the output register; the next request is
//   still accepted and worked on, and only its completion waits for the register to free up.
module text_console_cell_buffer import tccb_pkg::*; #(
  parameter int unsigned MAX_ROWS = 32,
  parameter int unsigned MAX_COLS = 128
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Request channel
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [CmdW-1:0]       cmd_i,
  input  logic [CharW-1:0]      char_code_i,
  input  logic [ReqRowW-1:0]    read_row_i,
  input  logic [ReqColW-1:0]    read_col_i,
  // Result channel
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [ReqRowW-1:0]    cursor_row_o,
  output logic [ReqColW-1:0]    cursor_col_o,
  output logic [CharW-1:0]      read_char_o,
  output logic                  scrolled_o,
  // Configuration write channel
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CfgIndexW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0]   cfg_data_i
);

  localparam int unsigned DEPTH = MAX_ROWS * MAX_COLS;
  localparam int unsigned AW    = $clog2(DEPTH);

  cfg_t             cfg_q;
  logic             mem_we;
  logic             mem_re;
  logic [AW-1:0]    mem_addr;
  logic [CharW-1:0] mem_wdata;
  logic [CharW-1:0] mem_rdata;

  assign cfg_ready_o = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rows_used    <= RowsUsedReset;
      cfg_q.columns_used <= ColumnsUsedReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CfgIdxRowsUsed:    cfg_q.rows_used    <= cfg_data_i[CfgRowsW-1:0];
        CfgIdxColumnsUsed: cfg_q.columns_used <= cfg_data_i[CfgColsW-1:0];
        default: begin
          cfg_q <= cfg_q;
        end
      endcase
    end
  end

  tccb_ctrl #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS),
    .DEPTH    (DEPTH),
    .AW       (AW)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .cmd_i        (cmd_i),
    .char_code_i  (char_code_i),
    .read_row_i   (read_row_i),
    .read_col_i   (read_col_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .cursor_row_o (cursor_row_o),
    .cursor_col_o (cursor_col_o),
    .read_char_o  (read_char_o),
    .scrolled_o   (scrolled_o),
    .mem_we_o     (mem_we),
    .mem_re_o     (mem_re),
    .mem_addr_o   (mem_addr),
    .mem_wdata_o  (mem_wdata),
    .mem_rdata_i  (mem_rdata)
  );

  tccb_cell_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_cell_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .re_i    (mem_re),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

endmodule
